// File: hw/rtl/fpr_pkg.sv
// ---------------------------------------------------------------------------
// FIFO page replacement package
// Shared key type and field widths for the page replacement block.
// ---------------------------------------------------------------------------
package fpr_pkg;

	localparam int PID_W = 16;
	localparam int VPN_W = 20;
	localparam int CNT_W = 7;

	// Opcodes carried on the input tuser.
	localparam logic OP_ACCESS = 1'b0;
	localparam logic OP_END    = 1'b1;

	// One resident page: process id and virtual page number.
	typedef struct packed {
		logic [PID_W-1:0] pid;
		logic [VPN_W-1:0] vpn;
	} key_t;

endpackage

// File: hw/rtl/fifo_page_replacement.sv
// ---------------------------------------------------------------------------
// FIFO page replacement
// Resident page list in arrival order with lookup, eviction and
// process-end compaction, run by a small sequencer over one key store.
// ---------------------------------------------------------------------------
// An access that hits stops scanning as soon as the matching page is read.
// The key store's single read port sets the pace: the sequencer reads and
// compares one resident page per cycle. The list is kept as a ring, so an
// eviction moves only the head pointer, and a process end rewrites the
// surviving pages in place behind the read pointer. One item is worked on
// at a time; s_tready is high only while idle, and a result beat stays on
// m_tdata until it is taken.
module fifo_page_replacement #(
	parameter int FRAMES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [6:0]  cfg_wdata,      // frame_limit
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,        // pid[15:0], vpn[35:16], zero fill
	input  logic        s_tuser,        // opcode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata         // hit[0], evicted[1], evicted_pid[17:2],
	                                    // evicted_vpn[37:18], removed_count[44:38],
	                                    // resident[51:45], zero fill
);

	localparam int AW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int CW = $clog2(FRAMES + 1);
	localparam int WW = (CW > fpr_pkg::CNT_W) ? CW : fpr_pkg::CNT_W;
	localparam int TW = CW + 1;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_FINISH = 2'd2;
	localparam logic [1:0] ST_OUT    = 2'd3;

	logic [1:0]          state_q;
	logic [6:0]          limit_q;
	logic                op_q;
	fpr_pkg::key_t       key_q;
	logic [AW-1:0]       head_q;
	logic [CW-1:0]       count_q;
	logic [CW-1:0]       rd_idx_q;
	logic [CW-1:0]       cmp_idx_q;
	logic [CW-1:0]       keep_q;
	logic [CW-1:0]       removed_q;
	logic [AW-1:0]       rd_ptr_q;
	logic [AW-1:0]       wr_ptr_q;
	logic                rvalid_s1;
	logic                hit_q;
	fpr_pkg::key_t       ev_key_q;
	logic [55:0]         out_q;
	logic                out_valid_q;

	fpr_pkg::key_t       rdata;
	logic                is_end;
	logic                issue;
	logic                cmp_en;
	logic                mem_we;
	logic [AW-1:0]       mem_waddr;
	fpr_pkg::key_t       mem_wdata;
	logic [TW-1:0]       tail_sum;
	logic [AW-1:0]       tail;
	logic [WW-1:0]       lim_w;
	logic [WW-1:0]       cap_w;
	logic [WW-1:0]       cnt_w;
	logic [55:0]         res_d;

	function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
		logic [AW-1:0] r;
		r = (p == AW'(FRAMES - 1)) ? '0 : p + AW'(1);
		return r;
	endfunction

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;
	assign is_end   = (op_q == fpr_pkg::OP_END);

	// Effective capacity: a zero limit acts as one, a limit above FRAMES is capped.
	always_comb begin
		lim_w = WW'(limit_q);
		cnt_w = WW'(count_q);
		if (limit_q == 7'd0) begin
			cap_w = WW'(1);
		end else if (lim_w > WW'(FRAMES)) begin
			cap_w = WW'(FRAMES);
		end else begin
			cap_w = lim_w;
		end
	end

	assign tail_sum = TW'(head_q) + TW'(count_q);
	assign tail     = (tail_sum >= TW'(FRAMES)) ? AW'(tail_sum - TW'(FRAMES)) : AW'(tail_sum);

	assign issue  = (state_q == ST_SCAN) && !hit_q && (rd_idx_q != count_q);
	assign cmp_en = (state_q == ST_SCAN) && rvalid_s1 && !hit_q;

	// Survivors of a process end are written back at the keep pointer, which
	// never passes the entry being read, so the scan never reads its own writes.
	always_comb begin
		if (state_q == ST_FINISH) begin
			mem_we    = !is_end && !hit_q;
			mem_waddr = tail;
			mem_wdata = key_q;
		end else begin
			mem_we    = cmp_en && is_end && (rdata.pid != key_q.pid);
			mem_waddr = wr_ptr_q;
			mem_wdata = rdata;
		end
	end

	always_comb begin
		res_d = '0;
		if (is_end) begin
			res_d[44:38] = 7'(removed_q);
			res_d[51:45] = 7'(keep_q);
		end else if (hit_q) begin
			res_d[0]     = 1'b1;
			res_d[51:45] = 7'(count_q);
		end else if (cnt_w >= cap_w) begin
			res_d[1]     = 1'b1;
			res_d[17:2]  = ev_key_q.pid;
			res_d[37:18] = ev_key_q.vpn;
			res_d[51:45] = 7'(count_q);
		end else begin
			res_d[51:45] = 7'(count_q + CW'(1));
		end
	end

	fpr_mem #(
		.DEPTH (FRAMES),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (rd_ptr_q),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= 7'd64;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q      <= '0;
			count_q     <= '0;
			rvalid_s1   <= 1'b0;
			out_valid_q <= 1'b0;
			hit_q       <= 1'b0;
			rd_idx_q    <= '0;
			cmp_idx_q   <= '0;
			keep_q      <= '0;
			removed_q   <= '0;
		end else begin
			rvalid_s1 <= issue;
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q   <= ST_SCAN;
						hit_q     <= 1'b0;
						rd_idx_q  <= '0;
						cmp_idx_q <= '0;
						keep_q    <= '0;
						removed_q <= '0;
					end
				end
				ST_SCAN: begin
					if (issue) begin
						rd_idx_q <= rd_idx_q + CW'(1);
					end
					if (cmp_en) begin
						cmp_idx_q <= cmp_idx_q + CW'(1);
						if (is_end) begin
							if (rdata.pid == key_q.pid) begin
								removed_q <= removed_q + CW'(1);
							end else begin
								keep_q <= keep_q + CW'(1);
							end
						end else if (rdata == key_q) begin
							hit_q <= 1'b1;
						end
					end
					if (hit_q || (cmp_idx_q == count_q)) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					state_q     <= ST_OUT;
					out_valid_q <= 1'b1;
					if (is_end) begin
						count_q <= keep_q;
					end else if (!hit_q) begin
						if (cnt_w >= cap_w) begin
							head_q <= ptr_inc(head_q);
						end else begin
							count_q <= count_q + CW'(1);
						end
					end
				end
				ST_OUT: begin
					if (m_tready) begin
						out_valid_q <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers: item key, scan pointers, eviction candidate, result.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				op_q     <= s_tuser;
				key_q    <= {s_tdata[15:0], s_tdata[35:16]};
				rd_ptr_q <= head_q;
				wr_ptr_q <= head_q;
				ev_key_q <= '0;
			end
			ST_SCAN: begin
				if (issue) begin
					rd_ptr_q <= ptr_inc(rd_ptr_q);
				end
				if (mem_we) begin
					wr_ptr_q <= ptr_inc(wr_ptr_q);
				end
				// The oldest page is the first one compared.
				if (cmp_en && (cmp_idx_q == '0)) begin
					ev_key_q <= rdata;
				end
			end
			ST_FINISH: begin
				out_q <= res_d;
			end
			ST_OUT: begin
			end
			default: begin
			end
		endcase
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(FRAMES))
		else $error("resident count above frame count");

	a_head_range: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= AW'(FRAMES - 1))
		else $error("head pointer outside the store");

	a_compact_balance: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) && is_end |-> (CW'(keep_q + removed_q) == cmp_idx_q))
		else $error("process-end scan lost track of entries");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input accepted while a result is pending");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (cmp_idx_q <= rd_idx_q) && (rd_idx_q <= count_q))
		else $error("scan pointers out of order");

endmodule

// File: hw/rtl/fpr_mem.sv
// ---------------------------------------------------------------------------
// FIFO page replacement key store
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module fpr_mem #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  fpr_pkg::key_t    wdata,
	input  logic [AW-1:0]    raddr,
	output fpr_pkg::key_t    rdata
);

	fpr_pkg::key_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// FIFO page replacement testbench
// Streams page accesses and process ends into the block and checks every
// result beat against an in-bench model of the resident page list. A short
// directed table covers the corner cases. Randomized traffic then runs under
// several frame limits and idle patterns, with one long receiver hold-off.
// ---------------------------------------------------------------------------
module tb_top;

	localparam int FRAMES       = 64;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int HOLD_CYCLES  = 600;
	localparam int SETTLE       = FRAMES + 8;
	localparam int PHASE_ITEMS  = 250;
	localparam int NUM_PHASES   = 6;
	localparam int NUM_ROWS     = 30;
	localparam int REPORT_MAX   = 10;

	typedef struct packed {
		logic                      hit;
		logic                      evicted;
		logic [fpr_pkg::PID_W-1:0] ev_pid;
		logic [fpr_pkg::VPN_W-1:0] ev_vpn;
		logic [fpr_pkg::CNT_W-1:0] removed;
		logic [fpr_pkg::CNT_W-1:0] resident;
	} page_result_t;

	typedef enum logic {ROW_BEAT, ROW_LIMIT} row_kind_e;

	typedef struct {
		row_kind_e                 kind;
		logic                      op;
		logic [fpr_pkg::PID_W-1:0] pid;
		logic [fpr_pkg::VPN_W-1:0] vpn;
		logic [fpr_pkg::CNT_W-1:0] limit;
		bit                        typed;
		page_result_t              want;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [6:0]  cfg_wdata;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;          // pid[15:0], vpn[35:16], zero fill
	logic        s_tuser;          // opcode
	logic        m_tvalid;
	logic        m_tready;
	logic [55:0] m_tdata;          // hit[0], evicted[1], evicted_pid[17:2],
	                               // evicted_vpn[37:18], removed_count[44:38],
	                               // resident[51:45], zero fill

	// Model of the resident list, oldest page at index 0.
	fpr_pkg::key_t             page_list [FRAMES];
	int                        page_count;
	logic [fpr_pkg::CNT_W-1:0] frame_limit_q;

	page_result_t pending_results [$];
	stim_row_t    directed_rows [NUM_ROWS];

	int src_idle_pct;
	int sink_stall_pct;
	bit hold_off_req;
	int mismatch_count;
	int beats_checked;
	int hit_count;
	int evict_count;
	int end_count;
	int limit_writes;
	int cycle_count;

	fifo_page_replacement u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > CYCLE_LIMIT) begin
				$display("Timeout after %0d cycles, %0d results outstanding",
					cycle_count, pending_results.size());
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	// Applies one item to the list model and returns the result it must produce.
	function automatic page_result_t apply_page_op(input logic op, input fpr_pkg::key_t key);
		page_result_t r;
		int cap;
		int keep;
		bit found;
		r = '0;
		found = 1'b0;
		keep = 0;
		cap = (frame_limit_q == 0) ? 1 : int'(frame_limit_q);
		if (cap > FRAMES)
			cap = FRAMES;
		if (op == fpr_pkg::OP_ACCESS) begin
			for (int i = 0; i < page_count; i++)
				if (page_list[i] == key)
					found = 1'b1;
			if (found) begin
				r.hit = 1'b1;
			end else begin
				// A lowered limit never drops pages; every miss then evicts one.
				if (page_count >= cap) begin
					r.evicted = 1'b1;
					r.ev_pid = page_list[0].pid;
					r.ev_vpn = page_list[0].vpn;
					for (int i = 1; i < page_count; i++)
						page_list[i-1] = page_list[i];
					page_count--;
				end
				if (page_count < FRAMES) begin
					page_list[page_count] = key;
					page_count++;
				end
			end
		end else begin
			for (int i = 0; i < page_count; i++) begin
				if (page_list[i].pid == key.pid) begin
					r.removed++;
				end else begin
					page_list[keep] = page_list[i];
					keep++;
				end
			end
			page_count = keep;
		end
		r.resident = page_count[fpr_pkg::CNT_W-1:0];
		return r;
	endfunction

	task automatic compare_result(input logic [55:0] beat);
		page_result_t got;
		page_result_t want;
		bit bad;
		got.hit      = beat[0];
		got.evicted  = beat[1];
		got.ev_pid   = beat[17:2];
		got.ev_vpn   = beat[37:18];
		got.removed  = beat[44:38];
		got.resident = beat[51:45];
		if (pending_results.size() == 0) begin
			mismatch_count++;
			if (mismatch_count <= REPORT_MAX)
				$display("Unexpected result beat at cycle %0d: %h", cycle_count, beat);
		end else begin
			want = pending_results.pop_front();
			beats_checked++;
			bad = (got.hit !== want.hit) || (got.evicted !== want.evicted) ||
				(got.ev_pid !== want.ev_pid) || (got.ev_vpn !== want.ev_vpn) ||
				(got.removed !== want.removed) || (got.resident !== want.resident);
			if (bad) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_MAX) begin
					$display("Mismatch at cycle %0d, result %0d", cycle_count, beats_checked);
					$display("  expected hit=%b ev=%b pid=%h vpn=%h removed=%0d resident=%0d",
						want.hit, want.evicted, want.ev_pid, want.ev_vpn,
						want.removed, want.resident);
					$display("  actual   hit=%b ev=%b pid=%h vpn=%h removed=%0d resident=%0d",
						got.hit, got.evicted, got.ev_pid, got.ev_vpn,
						got.removed, got.resident);
				end
			end
		end
	endtask

	// Result side: random stalls, plus one long hold-off on request.
	initial begin : result_sink
		int hold_left;
		bit hold_taken;
		hold_left = 0;
		hold_taken = 1'b0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready)
				compare_result(m_tdata);
			if (hold_off_req && !hold_taken) begin
				hold_taken = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= sink_stall_pct);
			end
		end
	end

	// Offers one beat and records its expected result once it is accepted.
	task automatic send_page_op(input logic op, input logic [fpr_pkg::PID_W-1:0] pid,
			input logic [fpr_pkg::VPN_W-1:0] vpn, input bit typed,
			input page_result_t want);
		fpr_pkg::key_t key;
		page_result_t predicted;
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {4'd0, vpn, pid};
		do @(posedge clk); while (!s_tready);
		key.pid = pid;
		key.vpn = vpn;
		predicted = apply_page_op(op, key);
		pending_results.push_back(typed ? want : predicted);
		if (predicted.hit)
			hit_count++;
		if (predicted.evicted)
			evict_count++;
		if (op == fpr_pkg::OP_END)
			end_count++;
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_frame_limit(input logic [fpr_pkg::CNT_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		frame_limit_q = value;
		limit_writes++;
	endtask

	// Random traffic over a small key pool so that hits, evictions and
	// process ends all occur, with some fully random keys mixed in.
	task automatic run_traffic_phase(input int count);
		logic [fpr_pkg::PID_W-1:0] pid_pool [6];
		logic [fpr_pkg::VPN_W-1:0] vpn_base;
		logic [fpr_pkg::PID_W-1:0] pid;
		logic [fpr_pkg::VPN_W-1:0] vpn;
		logic                      op;
		int                        cap;
		int                        vspan;
		int                        roll;
		foreach (pid_pool[i])
			pid_pool[i] = fpr_pkg::PID_W'($urandom);
		vpn_base = fpr_pkg::VPN_W'($urandom);
		cap = (frame_limit_q == 0) ? 1 : int'(frame_limit_q);
		if (cap > FRAMES)
			cap = FRAMES;
		vspan = cap / 3 + 2;
		for (int n = 0; n < count; n++) begin
			roll = $urandom_range(99);
			op = fpr_pkg::OP_ACCESS;
			pid = pid_pool[$urandom_range(5)];
			vpn = vpn_base ^ fpr_pkg::VPN_W'($urandom_range(vspan - 1));
			if (roll < 8) begin
				op = fpr_pkg::OP_END;
				vpn = fpr_pkg::VPN_W'($urandom);
				if ($urandom_range(3) == 0)
					pid = fpr_pkg::PID_W'($urandom);
			end else if (roll < 15) begin
				pid = fpr_pkg::PID_W'($urandom);
				vpn = fpr_pkg::VPN_W'($urandom);
			end
			send_page_op(op, pid, vpn, 1'b0, '0);
		end
	endtask

	initial begin : stimulus
		logic [fpr_pkg::CNT_W-1:0] phase_limit [NUM_PHASES];
		int                        phase_src [4];
		int                        phase_sink [4];

		directed_rows = '{
			// Reset limit of 64 is still in force for the first two.
			'{ROW_BEAT,  fpr_pkg::OP_ACCESS, 16'h0000, 20'h00000, 7'd0,   1'b1,
				'{1'b0, 1'b0, 16'h0000, 20'h00000, 7'd0, 7'd1}},
			'{ROW_BEAT,  fpr_pkg::OP_ACCESS, 16'hFFFF, 20'hFFFFF, 7'd0,   1'b1,
				'{1'b0, 1'b0, 16'h0000, 20'h00000, 7'd0, 7'd2}},
			'{ROW_LIMIT, fpr_pkg::OP_ACCESS, 16'h0000, 20'h00000, 7'd2,   1'b0, '0},
			'{ROW_BEAT,  fpr_pkg::OP_ACCESS, 16'h0000, 20'h00000, 7'd0,   1'b1,
				'{1'b1, 1'b0, 16'h0000, 20'h00000, 7'd0, 7'd2}},
			'{ROW_BEAT,  fpr_pkg::OP_ACCESS, 16'h0001, 20'h00005, 7'd0,   1'b1,
				'{1'b0, 1'b1, 16'h0000, 20'h00000, 7'd0, 7'd2}},
			'{ROW_BEAT,  fpr_pkg::OP_ACCESS, 16'h0002, 20'h00007, 7'd0,   1'b1,
				'{1'b0, 1'b1, 16'hFFFF, 20'hFFFFF, 7'd0, 7'd2}},
			// Process ends: one match, no match, last page, empty list.
			'{ROW_BEAT,  fpr_pkg::OP_END,    16'h0001, 20'hFFFFF, 7'd0,   1'b1,
				'{1'b0, 1'b0, 16'h0000, 20'h00000, 7'd1, 7'd1}},
			'{ROW_BEAT,  fpr_pkg::OP_END,    16'h0009, 20'h00000, 7'd0,   1'b1,
				'{1'b0, 1'b0, 16'h0000, 20'h00000, 7'd0, 7'd1}},
			'{ROW_BEAT,  fpr_pkg::OP_END,    16'h0002, 20'h00000, 7'd0,   1'b1,
				'{1'b0, 1'b0, 16'h0000, 20'h00000, 7'd1, 7'd0}},
			'{ROW_BEAT,  fpr_pkg::OP_END,    16'h0002, 20'h00000, 7'd0,   1'b1,
				'{1'b0, 1'b0, 16'h0000, 20'h00000, 7'd0, 7'd0}},
			// A limit of zero behaves as one frame.
			'{ROW_LIMIT, fpr_pkg::OP_ACCESS, 16'h0000, 20'h00000, 7'd0,   1'b0, '0},
			'{ROW_BEAT,  fpr_pkg::OP_ACCESS, 16'h0004, 20'h00004, 7'd0,   1'b1,
				'{1'b0, 1'b0, 16'h0000, 20'h00000, 7'd0, 7'd1}},
			'{ROW_BEAT,  fpr_pkg::OP_ACCESS, 16'h0004, 20'h00005, 7'd0,   1'b1,
				'{1'b0, 1'b1, 16'h0004, 20'h00004, 7'd0, 7'd1}},
			'{ROW_BEAT,  fpr_pkg::OP_ACCESS, 16'h0004, 20'h00005, 7'd0,   1'b1,
				'{1'b1, 1'b0, 16'h0000, 20'h00000, 7'd0, 7'd1}},
			'{ROW_LIMIT, fpr_pkg::OP_ACCESS, 16'h0000, 20'h00000, 7'd3,   1'b0, '0},
			'{ROW_BEAT,  fpr_pkg::OP_ACCESS, 16'h0006, 20'h00001, 7'd0,   1'b0, '0},
			'{ROW_BEAT,  fpr_pkg::OP_ACCESS, 16'h0007, 20'h00001, 7'd0,   1'b0, '0},
			'{ROW_BEAT,  fpr_pkg::OP_ACCESS, 16'h0006, 20'h00002, 7'd0,   1'b0, '0},
			// Limit drops below the three resident pages; none is dropped.
			'{ROW_LIMIT, fpr_pkg::OP_ACCESS, 16'h0000, 20'h00000, 7'd1,   1'b0, '0},
			'{ROW_BEAT,  fpr_pkg::OP_ACCESS, 16'h0008, 20'h00008, 7'd0,   1'b1,
				'{1'b0, 1'b1, 16'h0006, 20'h00001, 7'd0, 7'd3}},
			'{ROW_BEAT,  fpr_pkg::OP_ACCESS, 16'h0007, 20'h00001, 7'd0,   1'b1,
				'{1'b1, 1'b0, 16'h0000, 20'h00000, 7'd0, 7'd3}},
			'{ROW_BEAT,  fpr_pkg::OP_END,    16'h0007, 20'h00003, 7'd0,   1'b1,
				'{1'b0, 1'b0, 16'h0000, 20'h00000, 7'd1, 7'd2}},
			'{ROW_BEAT,  fpr_pkg::OP_ACCESS, 16'h0009, 20'h00009, 7'd0,   1'b0, '0},
			// A limit above the frame count is capped.
			'{ROW_LIMIT, fpr_pkg::OP_ACCESS, 16'h0000, 20'h00000, 7'd127, 1'b0, '0},
			'{ROW_BEAT,  fpr_pkg::OP_ACCESS, 16'h000A, 20'h0000A, 7'd0,   1'b0, '0},
			'{ROW_BEAT,  fpr_pkg::OP_END,    16'h0008, 20'h00000, 7'd0,   1'b0, '0},
			'{ROW_BEAT,  fpr_pkg::OP_ACCESS, 16'hFFFF, 20'h00000, 7'd0,   1'b0, '0},
			'{ROW_BEAT,  fpr_pkg::OP_ACCESS, 16'h0000, 20'hFFFFF, 7'd0,   1'b0, '0},
			'{ROW_BEAT,  fpr_pkg::OP_ACCESS, 16'hFFFF, 20'hFFFFF, 7'd0,   1'b0, '0},
			'{ROW_BEAT,  fpr_pkg::OP_END,    16'hFFFF, 20'hFFFFF, 7'd0,   1'b0, '0}
		};
		phase_limit = '{7'd4, 7'd127, 7'd1, 7'd64, 7'd0, 7'd0};
		phase_limit[NUM_PHASES-1] = fpr_pkg::CNT_W'($urandom_range(16, 2));
		phase_src  = '{0, 57, 0, 31};
		phase_sink = '{0, 0, 57, 31};

		page_count = 0;
		frame_limit_q = 7'd64;
		foreach (page_list[i])
			page_list[i] = '0;
		src_idle_pct = 20;
		sink_stall_pct = 20;
		hold_off_req = 1'b0;
		mismatch_count = 0;
		beats_checked = 0;
		hit_count = 0;
		evict_count = 0;
		end_count = 0;
		limit_writes = 0;

		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_wdata <= 7'd0;
		s_tvalid  <= 1'b0;
		s_tuser   <= fpr_pkg::OP_ACCESS;
		s_tdata   <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[r]) begin
			if (directed_rows[r].kind == ROW_LIMIT) begin
				wait_drained();
				write_frame_limit(directed_rows[r].limit);
			end else begin
				send_page_op(directed_rows[r].op, directed_rows[r].pid,
					directed_rows[r].vpn, directed_rows[r].typed, directed_rows[r].want);
			end
		end

		for (int p = 0; p < NUM_PHASES; p++) begin
			wait_drained();
			repeat (SETTLE) @(posedge clk);
			write_frame_limit(phase_limit[p]);
			src_idle_pct = phase_src[p % 4];
			sink_stall_pct = phase_sink[p % 4];
			// The first phase sends back to back so the stalled output backs
			// up into the input.
			if (p == 0)
				hold_off_req = 1'b1;
			run_traffic_phase(PHASE_ITEMS);
		end

		wait_drained();
		repeat (SETTLE) @(posedge clk);
		$display("Checked %0d results over %0d frame limit writes: %0d hits, %0d evictions,",
			beats_checked, limit_writes, hit_count, evict_count);
		$display("%0d process ends, %0d mismatching beats", end_count, mismatch_count);
		if (mismatch_count == 0 && pending_results.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
